### rtl/command_queue_with_byte_ring_core_assert.svh
// ----------------------------------------------------------------------------
// Command queue assertion macros
// Shared property forms for the command queue checks.
// ----------------------------------------------------------------------------
`ifndef COMMAND_QUEUE_WITH_BYTE_RING_CORE_ASSERT_SVH
`define COMMAND_QUEUE_WITH_BYTE_RING_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CQBR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cqbr: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define CQBR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cqbr: next-cycle check failed");

`endif

### rtl/cqbr_pkg.sv
// ----------------------------------------------------------------------------
// Command queue package
// Shared codes, widths and the request record passed from front to back.
// ----------------------------------------------------------------------------
package cqbr_pkg;

  localparam int unsigned SlotsDef  = 32;
  localparam int unsigned BytesDef  = 512;
  localparam int unsigned MaxLenDef = 128;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned DataW   = 8;
  localparam int unsigned LenW    = 8;
  localparam int unsigned StatusW = 3;

  // Depth of the queue between front and back.
  localparam int unsigned QueueDepth = 2;

  localparam logic [CmdW-1:0] CMD_LOAD = 2'd0;
  localparam logic [CmdW-1:0] CMD_PULL = 2'd1;
  localparam logic [CmdW-1:0] CMD_RESP = 2'd2;

  localparam logic [StatusW-1:0] ST_OK       = 3'd0;
  localparam logic [StatusW-1:0] ST_NO_SLOT  = 3'd1;
  localparam logic [StatusW-1:0] ST_TOO_LONG = 3'd2;
  localparam logic [StatusW-1:0] ST_NO_SPACE = 3'd3;
  localparam logic [StatusW-1:0] ST_IDLE     = 3'd4;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_PULL,
    OP_RESP,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [DataW-1:0] data;
    logic [LenW-1:0]  len;
  } item_t;

endpackage

### rtl/command_queue_with_byte_ring_core.sv
// ----------------------------------------------------------------------------
// Command queue with byte ring
// Queues variable-length commands in a wrapping byte ring with a descriptor
// ring, and hands them out one byte per pull request.
// ----------------------------------------------------------------------------
// Push one request per cycle: a command byte to load (with the total command
// length on every byte), a pull for the next outgoing byte, or a response that
// retires the outstanding command. Every request yields exactly one result,
// in order, on the pop side. The first byte of a command claims a descriptor
// and all of its bytes at once, or is rejected (no descriptor, too long, too
// little byte space), in which case the rest of that command is dropped with
// status "nothing to do". A command becomes eligible for pulling once its last
// byte is loaded; only one command is outstanding until its response arrives.
// Throughput is one request per cycle while no result waits unpopped, set by
// the single execution stage that updates the ring pointers and reads the
// byte memory. A request passes the front register, the two-entry queue and
// the execution stage that fills the result register. Backpressure appears on
// full only while results wait to be popped. No clearing pass runs after
// reset; the ring memories hold stale data that is never read before written.
// ----------------------------------------------------------------------------
`include "command_queue_with_byte_ring_core_assert.svh"

module command_queue_with_byte_ring_core import cqbr_pkg::*; #(
  parameter int unsigned SLOTS   = SlotsDef,
  parameter int unsigned BYTES   = BytesDef,
  parameter int unsigned MAX_LEN = MaxLenDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Request side
  input  logic               push,
  output logic               full,
  input  logic [CmdW-1:0]    command_i,
  input  logic [DataW-1:0]   data_byte_i,
  input  logic [LenW-1:0]    cmd_length_i,
  // Result side
  output logic               empty,
  input  logic               pop,
  output logic [StatusW-1:0] status_o,
  output logic               out_valid_o,
  output logic [DataW-1:0]   out_byte_o,
  output logic               out_last_o,
  output logic [LenW-1:0]    out_length_o
);

  logic  front_valid;
  item_t front_item;
  logic  q_full;
  logic  q_empty;
  item_t q_item;
  logic  back_ready;
  logic  res_valid;

  // Result classes seen by the checks at the end.
  logic  byte_res;
  logic  byte_res_ok;
  logic  plain_res;
  logic  plain_res_clear;

  // Decode and register incoming requests.
  cqbr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .command_i    (command_i),
    .data_byte_i  (data_byte_i),
    .cmd_length_i (cmd_length_i),
    .item_valid_o (front_valid),
    .item_o       (front_item),
    .item_ready_i (!q_full)
  );

  // Decouple the front from the back so either side can stall.
  cqbr_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (front_valid),
    .wr_item_i (front_item),
    .full_o    (q_full),
    .pop_i     (back_ready),
    .rd_item_o (q_item),
    .empty_o   (q_empty)
  );

  // Execute against the rings and hold the result until popped.
  cqbr_back #(
    .SLOTS   (SLOTS),
    .BYTES   (BYTES),
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!q_empty),
    .item_i       (q_item),
    .item_ready_o (back_ready),
    .res_valid_o  (res_valid),
    .pop_i        (pop),
    .status_o     (status_o),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o),
    .out_length_o (out_length_o)
  );

  assign empty = !res_valid;

  assign byte_res        = !empty && out_valid_o;
  assign byte_res_ok     = (status_o == ST_OK) && (out_length_o != '0) &&
                           (out_length_o <= LenW'(MAX_LEN));
  assign plain_res       = !empty && !out_valid_o;
  assign plain_res_clear = (out_byte_o == '0) && !out_last_o && (out_length_o == '0);

  // A byte result always reports success and a length within the limit.
  `CQBR_ASSERT_IMP(a_byte_ok, clk_i, rst_ni, byte_res, byte_res_ok)
  // Non-byte results carry no byte, last flag or length.
  `CQBR_ASSERT_IMP(a_no_byte_clear, clk_i, rst_ni, plain_res, plain_res_clear)
  // Backpressure only builds up behind a waiting result.
  `CQBR_ASSERT_NXT(a_full_result, clk_i, rst_ni, full, !empty)

endmodule

### rtl/cqbr_front.sv
// ----------------------------------------------------------------------------
// Command queue front stage
// Accepts requests, decodes the command code and registers the request.
// ----------------------------------------------------------------------------
module cqbr_front import cqbr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [CmdW-1:0]  command_i,
  input  logic [DataW-1:0] data_byte_i,
  input  logic [LenW-1:0]  cmd_length_i,
  output logic             item_valid_o,
  output item_t            item_o,
  input  logic             item_ready_i
);

  logic  stage_valid_q, stage_valid_d;
  item_t stage_q;
  op_e   op_d;
  logic  accept;

  always_comb begin
    case (command_i)
      CMD_LOAD: op_d = OP_LOAD;
      CMD_PULL: op_d = OP_PULL;
      CMD_RESP: op_d = OP_RESP;
      default:  op_d = OP_NONE;
    endcase
  end

  // Hold off new requests only while the stage is occupied and cannot drain.
  assign full_o = stage_valid_q && !item_ready_i;
  assign accept = push_i && !full_o;

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (accept) begin
      stage_valid_d = 1'b1;
    end else if (item_ready_i) begin
      stage_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= '{op: op_d, data: data_byte_i, len: cmd_length_i};
    end
  end

  assign item_valid_o = stage_valid_q;
  assign item_o       = stage_q;

endmodule

### rtl/cqbr_fifo.sv
// ----------------------------------------------------------------------------
// Command queue decoupling FIFO
// Short request queue that lets front and back stall independently.
// ----------------------------------------------------------------------------
module cqbr_fifo import cqbr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t wr_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t rd_item_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  item_t            entry_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= wr_item_i;
    end
  end

  assign rd_item_o = entry_q[rd_ptr_q];

endmodule

### rtl/cqbr_back.sv
// ----------------------------------------------------------------------------
// Command queue back end
// Executes load, pull and response requests against the byte and slot rings.
// ----------------------------------------------------------------------------
module cqbr_back import cqbr_pkg::*; #(
  parameter int unsigned SLOTS   = SlotsDef,
  parameter int unsigned BYTES   = BytesDef,
  parameter int unsigned MAX_LEN = MaxLenDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  item_t              item_i,
  output logic               item_ready_o,
  output logic               res_valid_o,
  input  logic               pop_i,
  output logic [StatusW-1:0] status_o,
  output logic               out_valid_o,
  output logic [DataW-1:0]   out_byte_o,
  output logic               out_last_o,
  output logic [LenW-1:0]    out_length_o
);

  localparam int unsigned SlotW    = $clog2(SLOTS);
  localparam int unsigned SlotCntW = $clog2(SLOTS + 1);
  localparam int unsigned PosW     = $clog2(BYTES);
  localparam int unsigned ByteCntW = $clog2(BYTES + 1);

  // Rings
  logic [DataW-1:0] byte_mem   [BYTES];
  logic [PosW-1:0]  slot_start [SLOTS];
  logic [LenW-1:0]  slot_len   [SLOTS];

  // Ring control
  logic [SlotW-1:0]    slot_wr_q, slot_wr_d;
  logic [SlotW-1:0]    slot_rd_q, slot_rd_d;
  logic [SlotCntW-1:0] slots_free_q, slots_free_d;
  logic [PosW-1:0]     byte_wr_q, byte_wr_d;
  logic [ByteCntW-1:0] bytes_free_q, bytes_free_d;
  logic                awaiting_q, awaiting_d;
  logic [PosW-1:0]     send_pos_q, send_pos_d;
  logic [LenW-1:0]     send_left_q, send_left_d;
  logic [LenW-1:0]     load_left_q, load_left_d;
  logic                load_rej_q, load_rej_d;

  // Head descriptor, registered read of the slot ring at the read index
  logic [PosW-1:0] head_start_q;
  logic [LenW-1:0] head_len_q;

  // Result register
  logic               res_valid_q, res_valid_d;
  logic [StatusW-1:0] res_status_q, res_status_d;
  logic               res_byte_q, res_byte_d;
  logic               res_last_q, res_last_d;
  logic [LenW-1:0]    res_len_q, res_len_d;
  logic [DataW-1:0]   rd_data_q;

  logic            exec;
  logic            byte_we;
  logic            slot_we;
  logic            rd_en;
  logic [PosW-1:0] rd_addr;
  logic [SlotCntW-1:0] used;
  logic            loading;
  logic            complete_nz;
  logic            start;
  logic            active;
  logic [PosW-1:0] pos;
  logic [LenW-1:0] left;

  assign exec         = item_valid_i && (!res_valid_q || pop_i);
  assign item_ready_o = exec;

  assign used        = SlotCntW'(SLOTS) - slots_free_q;
  assign loading     = (load_left_q != '0) && !load_rej_q;
  assign complete_nz = used > SlotCntW'(loading);

  always_comb begin
    slot_wr_d    = slot_wr_q;
    slot_rd_d    = slot_rd_q;
    slots_free_d = slots_free_q;
    byte_wr_d    = byte_wr_q;
    bytes_free_d = bytes_free_q;
    awaiting_d   = awaiting_q;
    send_pos_d   = send_pos_q;
    send_left_d  = send_left_q;
    load_left_d  = load_left_q;
    load_rej_d   = load_rej_q;
    byte_we      = 1'b0;
    slot_we      = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = send_pos_q;
    start        = 1'b0;
    active       = 1'b0;
    pos          = send_pos_q;
    left         = send_left_q;
    res_status_d = ST_IDLE;
    res_byte_d   = 1'b0;
    res_last_d   = 1'b0;
    res_len_d    = '0;

    if (exec) begin
      case (item_i.op)
        OP_LOAD: begin
          if (load_left_q != '0) begin
            // Continuation byte: store it or drop it with its rejected command.
            load_left_d = load_left_q - 1'b1;
            if (load_rej_q) begin
              if (load_left_q == LenW'(1)) begin
                load_rej_d = 1'b0;
              end
            end else begin
              byte_we      = 1'b1;
              res_status_d = ST_OK;
            end
          end else if (item_i.len != '0) begin
            // First byte: check slot, length limit and space, in that order.
            if (slots_free_q == '0) begin
              res_status_d = ST_NO_SLOT;
            end else if (item_i.len > LenW'(MAX_LEN)) begin
              res_status_d = ST_TOO_LONG;
            end else if (bytes_free_q < ByteCntW'(item_i.len)) begin
              res_status_d = ST_NO_SPACE;
            end else begin
              res_status_d = ST_OK;
            end
            load_left_d = item_i.len - 1'b1;
            if (res_status_d != ST_OK) begin
              load_rej_d = (item_i.len != LenW'(1));
            end else begin
              load_rej_d   = 1'b0;
              slot_we      = 1'b1;
              slot_wr_d    = (slot_wr_q == SlotW'(SLOTS - 1)) ? '0 : slot_wr_q + 1'b1;
              slots_free_d = slots_free_q - 1'b1;
              bytes_free_d = bytes_free_q - ByteCntW'(item_i.len);
              byte_we      = 1'b1;
            end
          end
          if (byte_we) begin
            byte_wr_d = (byte_wr_q == PosW'(BYTES - 1)) ? '0 : byte_wr_q + 1'b1;
          end
        end
        OP_PULL: begin
          // Open the oldest complete command if none is outstanding.
          start  = !awaiting_q && complete_nz;
          pos    = start ? head_start_q : send_pos_q;
          left   = start ? head_len_q : send_left_q;
          active = awaiting_q || start;
          awaiting_d  = active;
          send_pos_d  = pos;
          send_left_d = left;
          if (active && (left != '0)) begin
            rd_en        = 1'b1;
            rd_addr      = pos;
            send_pos_d   = (pos == PosW'(BYTES - 1)) ? '0 : pos + 1'b1;
            send_left_d  = left - 1'b1;
            res_byte_d   = 1'b1;
            res_last_d   = (left == LenW'(1));
            res_len_d    = head_len_q;
            res_status_d = ST_OK;
          end
        end
        OP_RESP: begin
          // Retire the outstanding command and release its slot and bytes.
          if (awaiting_q) begin
            bytes_free_d = bytes_free_q + ByteCntW'(head_len_q);
            slot_rd_d    = (slot_rd_q == SlotW'(SLOTS - 1)) ? '0 : slot_rd_q + 1'b1;
            slots_free_d = slots_free_q + 1'b1;
            awaiting_d   = 1'b0;
            send_left_d  = '0;
            res_status_d = ST_OK;
          end
        end
        default: begin
          res_status_d = ST_IDLE;
        end
      endcase
    end

    res_valid_d = res_valid_q;
    if (exec) begin
      res_valid_d = 1'b1;
    end else if (pop_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_wr_q    <= '0;
      slot_rd_q    <= '0;
      slots_free_q <= SlotCntW'(SLOTS);
      byte_wr_q    <= '0;
      bytes_free_q <= ByteCntW'(BYTES);
      awaiting_q   <= 1'b0;
      send_pos_q   <= '0;
      send_left_q  <= '0;
      load_left_q  <= '0;
      load_rej_q   <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      slot_wr_q    <= slot_wr_d;
      slot_rd_q    <= slot_rd_d;
      slots_free_q <= slots_free_d;
      byte_wr_q    <= byte_wr_d;
      bytes_free_q <= bytes_free_d;
      awaiting_q   <= awaiting_d;
      send_pos_q   <= send_pos_d;
      send_left_q  <= send_left_d;
      load_left_q  <= load_left_d;
      load_rej_q   <= load_rej_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      res_status_q <= res_status_d;
      res_byte_q   <= res_byte_d;
      res_last_q   <= res_last_d;
      res_len_q    <= res_len_d;
    end
  end

  // Byte ring: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (byte_we) begin
      byte_mem[byte_wr_q] <= item_i.data;
    end
    if (rd_en) begin
      rd_data_q <= byte_mem[rd_addr];
    end
  end

  // Slot ring: write at the write index, read at the next read index.
  // Forward a descriptor written to the slot being read in the same cycle.
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_start[slot_wr_q] <= byte_wr_q;
      slot_len[slot_wr_q]   <= item_i.len;
    end
    if (slot_we && (slot_wr_q == slot_rd_d)) begin
      head_start_q <= byte_wr_q;
      head_len_q   <= item_i.len;
    end else begin
      head_start_q <= slot_start[slot_rd_d];
      head_len_q   <= slot_len[slot_rd_d];
    end
  end

  assign res_valid_o  = res_valid_q;
  assign status_o     = res_status_q;
  assign out_valid_o  = res_byte_q;
  assign out_byte_o   = res_byte_q ? rd_data_q : '0;
  assign out_last_o   = res_last_q;
  assign out_length_o = res_len_q;

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Command queue with byte ring testbench
// Drives load, pull and response requests into the queue and scores every
// result against a cycle-free model of the descriptor ring and byte ring.
// It runs directed cases, descriptor and byte exhaustion, and random traffic
// under three sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module testbench;
  import cqbr_pkg::*;

  // Code 3 has no meaning to the block; it must come back as nothing to do.
  localparam logic [CmdW-1:0] CMD_SPARE = 2'd3;

  localparam int unsigned SlotAw     = $clog2(SlotsDef);
  localparam int unsigned ByteAw     = $clog2(BytesDef);
  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned HoldCycles = 300;

  // One expected result per request.
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               valid;
    logic [DataW-1:0]   data;
    logic               last;
    logic [LenW-1:0]    length;
  } reply_t;

  logic               clk_i;
  logic               rst_ni       = 1'b0;
  logic               push         = 1'b0;
  logic               full;
  logic [CmdW-1:0]    command_i    = CMD_LOAD;
  logic [DataW-1:0]   data_byte_i  = '0;
  logic [LenW-1:0]    cmd_length_i = '0;
  logic               empty;
  logic               pop          = 1'b0;
  logic [StatusW-1:0] status_o;
  logic               out_valid_o;
  logic [DataW-1:0]   out_byte_o;
  logic               out_last_o;
  logic [LenW-1:0]    out_length_o;

  reply_t      replies_due[$];
  int unsigned error_count   = 0;
  int unsigned items_sent    = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        pop_hold      = 1'b0;

  // Model of the rings: contents, descriptors and the load / send trackers.
  logic [DataW-1:0]  ring_bytes [BytesDef];
  logic [ByteAw-1:0] desc_start [SlotsDef];
  logic [LenW-1:0]   desc_len   [SlotsDef];
  logic [SlotAw-1:0] desc_wr;
  logic [SlotAw-1:0] desc_rd;
  logic [SlotAw:0]   desc_free;
  logic [ByteAw-1:0] ring_wr;
  logic [ByteAw:0]   ring_free;
  logic              in_flight;
  logic [ByteAw-1:0] tx_pos;
  logic [LenW-1:0]   tx_left;
  logic [LenW-1:0]   rx_left;
  logic              rx_dropping;

  command_queue_with_byte_ring_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .command_i    (command_i),
    .data_byte_i  (data_byte_i),
    .cmd_length_i (cmd_length_i),
    .empty        (empty),
    .pop          (pop),
    .status_o     (status_o),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o),
    .out_length_o (out_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block wedges or drops a result.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Advance the model by one accepted request and queue the result it causes.
  task automatic predict_reply(input logic [CmdW-1:0] cmd, input logic [DataW-1:0] data,
                               input logic [LenW-1:0] len);
    reply_t      r;
    int unsigned ready;
    r        = '0;
    r.status = ST_IDLE;
    case (cmd)
      CMD_LOAD: begin
        if (rx_left != 0) begin
          // Continuation byte: store it, or drop it if the command was refused.
          rx_left = rx_left - 1'b1;
          if (rx_dropping) begin
            if (rx_left == 0) rx_dropping = 1'b0;
          end else begin
            ring_bytes[ring_wr] = data;
            ring_wr             = ring_wr + 1'b1;
            r.status            = ST_OK;
          end
        end else if (len != 0) begin
          // First byte: the checks run in this order.
          if (desc_free == 0) r.status = ST_NO_SLOT;
          else if (len > MaxLenDef) r.status = ST_TOO_LONG;
          else if (ring_free < len) r.status = ST_NO_SPACE;
          else r.status = ST_OK;
          rx_left     = len - 1'b1;
          rx_dropping = (r.status != ST_OK) && (rx_left != 0);
          if (r.status == ST_OK) begin
            desc_start[desc_wr] = ring_wr;
            desc_len[desc_wr]   = len;
            desc_wr             = desc_wr + 1'b1;
            desc_free           = desc_free - 1'b1;
            ring_free           = ring_free - len;
            ring_bytes[ring_wr] = data;
            ring_wr             = ring_wr + 1'b1;
          end
        end
      end
      CMD_PULL: begin
        // A command still being loaded holds a descriptor but is not ready.
        ready = SlotsDef - desc_free;
        if (rx_left != 0 && !rx_dropping && ready > 0) ready--;
        if (!in_flight && ready > 0) begin
          in_flight = 1'b1;
          tx_pos    = desc_start[desc_rd];
          tx_left   = desc_len[desc_rd];
        end
        if (in_flight && tx_left != 0) begin
          r.data   = ring_bytes[tx_pos];
          tx_pos   = tx_pos + 1'b1;
          tx_left  = tx_left - 1'b1;
          r.valid  = 1'b1;
          r.last   = (tx_left == 0);
          r.length = desc_len[desc_rd];
          r.status = ST_OK;
        end
      end
      CMD_RESP: begin
        if (in_flight) begin
          ring_free = ring_free + desc_len[desc_rd];
          desc_rd   = desc_rd + 1'b1;
          desc_free = desc_free + 1'b1;
          in_flight = 1'b0;
          tx_left   = '0;
          r.status  = ST_OK;
        end
      end
      default: ;
    endcase
    replies_due.push_back(r);
  endtask

  // Offer one request and hold it until the block takes it. Called at a
  // rising edge; returns at the edge that accepted the request.
  task automatic send_request(input logic [CmdW-1:0] cmd, input logic [DataW-1:0] data,
                              input logic [LenW-1:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push         <= 1'b1;
    command_i    <= cmd;
    data_byte_i  <= data;
    cmd_length_i <= len;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_reply(cmd, data, len);
    items_sent++;
  endtask

  // Send a request whose data and length carry random filler.
  task automatic send_bare(input logic [CmdW-1:0] cmd);
    send_request(cmd, DataW'($urandom), LenW'($urandom));
  endtask

  // Load a whole command with random content; mix_pct slips pulls and
  // responses in between its bytes.
  task automatic load_command(input int unsigned len, input int unsigned mix_pct);
    int unsigned i;
    send_request(CMD_LOAD, DataW'($urandom), LenW'(len));
    for (i = 1; i < len; i++) begin
      if ($urandom_range(99) < mix_pct)
        send_bare($urandom_range(1) ? CMD_PULL : CMD_RESP);
      send_request(CMD_LOAD, DataW'($urandom), LenW'(len));
    end
  endtask

  // Drop the request line and hold until every result is back.
  task automatic wait_all_replies();
    push <= 1'b0;
    do @(posedge clk_i); while (replies_due.size() != 0);
  endtask

  // Retire every queued command: start it, take one byte, answer it early.
  task automatic retire_all();
    while (desc_free != SlotsDef) begin
      if (!in_flight) send_bare(CMD_PULL);
      send_bare(CMD_RESP);
    end
  endtask

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      error_count++;
    end
  endfunction

  // Result side: score each popped result against the oldest expectation,
  // then decide whether to pop on the next edge.
  always @(posedge clk_i) begin
    reply_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (replies_due.size() == 0) begin
          $error("result popped with no request outstanding");
          error_count++;
        end else begin
          want = replies_due.pop_front();
          check_field("status", 32'(want.status), 32'(status_o));
          check_field("out_valid", 32'(want.valid), 32'(out_valid_o));
          check_field("out_byte", 32'(want.data), 32'(out_byte_o));
          check_field("out_last", 32'(want.last), 32'(out_last_o));
          check_field("out_length", 32'(want.length), 32'(out_length_o));
        end
      end
      pop <= !pop_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Requests that find nothing to do, plus a short life of three commands:
  // pull before completion, early response, pull after the last byte.
  task automatic test_directed();
    send_request(CMD_PULL, 8'h00, 8'h00);
    send_request(CMD_RESP, 8'hff, 8'hff);
    send_request(CMD_SPARE, 8'hff, 8'hff);
    send_request(CMD_LOAD, 8'haa, 8'd0);
    send_request(CMD_LOAD, 8'h00, 8'd1);
    send_request(CMD_PULL, 8'h00, 8'h00);
    send_request(CMD_PULL, 8'h00, 8'h00);
    send_request(CMD_RESP, 8'h00, 8'h00);
    send_request(CMD_LOAD, 8'hff, 8'd3);
    send_request(CMD_PULL, 8'h00, 8'h00);
    send_request(CMD_LOAD, 8'h5a, 8'd3);
    send_request(CMD_RESP, 8'h00, 8'h00);
    send_request(CMD_LOAD, 8'ha5, 8'd3);
    send_request(CMD_PULL, 8'h00, 8'h00);
    send_request(CMD_PULL, 8'h00, 8'h00);
    send_request(CMD_RESP, 8'h00, 8'h00);
    send_request(CMD_PULL, 8'h00, 8'h00);
    send_request(CMD_LOAD, 8'h80, 8'd2);
    send_request(CMD_LOAD, 8'h7f, 8'd2);
    send_request(CMD_PULL, 8'h00, 8'h00);
    send_request(CMD_PULL, 8'h00, 8'h00);
    send_request(CMD_PULL, 8'h00, 8'h00);
    send_request(CMD_RESP, 8'h00, 8'h00);
    send_request(CMD_SPARE, 8'h00, 8'h00);
  endtask

  // Commands over the length limit, the longest one included.
  task automatic test_too_long();
    load_command(255, 0);
    load_command(MaxLenDef + 1, 0);
    load_command(MaxLenDef, 0);
    retire_all();
  endtask

  // Use up every descriptor while the receiver holds off, so that the
  // block backs up into its request side; the next command is refused.
  task automatic test_descriptor_exhaustion();
    int unsigned i;
    retire_all();
    fork
      begin
        pop_hold <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        pop_hold <= 1'b0;
      end
      begin
        for (i = 0; i < SlotsDef; i++) load_command(1, 0);
        load_command(2, 0);
      end
    join
    send_bare(CMD_PULL);
    send_bare(CMD_RESP);
    load_command(3, 0);
    retire_all();
  endtask

  // Fill the byte ring to the last byte; a command that does not fit is refused.
  task automatic test_byte_space();
    retire_all();
    load_command(MaxLenDef, 0);
    load_command(MaxLenDef, 0);
    load_command(MaxLenDef, 0);
    load_command(BytesDef - 3 * MaxLenDef - 8, 0);
    load_command(9, 0);
    load_command(8, 0);
    load_command(1, 0);
    retire_all();
    load_command(1, 0);
  endtask

  // Random mix of commands, pull bursts and responses. The drain share
  // drifts so the rings fill up, run dry and wrap.
  task automatic test_random_traffic(input int unsigned sender_pct,
                                     input int unsigned receiver_pct,
                                     input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    int unsigned drain_pct;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    stop_at       = items_sent + count;
    drain_pct     = $urandom_range(10, 90);
    while (items_sent < stop_at) begin
      if ($urandom_range(31) == 0) drain_pct = $urandom_range(5, 95);
      pick = $urandom_range(99);
      if (pick < 35) begin
        pick = $urandom_range(99);
        if (pick < 3) len = 0;
        else if (pick < 65) len = $urandom_range(1, 8);
        else if (pick < 90) len = $urandom_range(9, 48);
        else if (pick < 98) len = $urandom_range(49, MaxLenDef);
        else len = $urandom_range(MaxLenDef + 1, 255);
        load_command(len, 6);
      end else if (pick < 55) begin
        if ($urandom_range(3) == 0) begin
          repeat ($urandom_range(1, 4)) send_bare(CMD_PULL);
        end else begin
          send_bare(CMD_PULL);
          while (in_flight && tx_left != 0) send_bare(CMD_PULL);
        end
      end else if (pick < 90 && $urandom_range(99) < drain_pct) begin
        // Retire one command, now and then before its last byte went out.
        send_bare(CMD_PULL);
        if ($urandom_range(4) != 0)
          while (in_flight && tx_left != 0) send_bare(CMD_PULL);
        send_bare(CMD_RESP);
      end else begin
        send_bare($urandom_range(1) ? CMD_SPARE : CMD_RESP);
      end
    end
  endtask

  initial begin
    // Model state out of reset.
    desc_wr     = '0;
    desc_rd     = '0;
    desc_free   = (SlotAw + 1)'(SlotsDef);
    ring_wr     = '0;
    ring_free   = (ByteAw + 1)'(BytesDef);
    in_flight   = 1'b0;
    tx_pos      = '0;
    tx_left     = '0;
    rx_left     = '0;
    rx_dropping = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 35;
    recv_idle_pct = 87;
    test_directed();
    test_too_long();
    test_descriptor_exhaustion();
    test_byte_space();
    // Pause the request side until everything is back.
    wait_all_replies();

    test_random_traffic(35, 87, 95);
    wait_all_replies();
    test_random_traffic(87, 35, 95);
    wait_all_replies();
    test_random_traffic(0, 0, 90);

    // Drain, then give the pipeline time to show any stray result.
    wait_all_replies();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
